// ===== hw/rtl/fpmu_pkg.sv =====
// fpmu_pkg: shared types and constants for the 16.16 fixed-point math unit
// no dependencies
package fpmu_pkg;

  localparam logic [2:0] CMD_MUL  = 3'd0;
  localparam logic [2:0] CMD_DIV  = 3'd1;
  localparam logic [2:0] CMD_FLT  = 3'd2;
  localparam logic [2:0] CMD_ABS  = 3'd3;
  localparam logic [2:0] CMD_SQRT = 3'd4;
  localparam logic [2:0] CMD_CBRT = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_DIVZERO  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;
  localparam logic [1:0] ST_ITERLIM  = 2'd3;

  localparam logic signed [31:0] FIX_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] FIX_MIN = 32'sh80000000;
  localparam logic signed [31:0] FIX_TWO = 32'sh00020000;
  localparam logic signed [33:0] STEP_TOL = 34'sd6;
  // ceil(2^33 / 3): exact divide by three of a 32-bit magnitude after >> 33
  localparam logic [31:0] RECIP3 = 32'haaaaaaab;

  // datapath operations issued by the controller
  typedef enum logic [3:0] {
    OP_LOAD   = 4'd0,  // latch operands, simple commands resolve
    OP_MUL    = 4'd1,  // product a*b into mul register
    OP_MULOUT = 4'd2,  // result from product
    OP_SQ     = 4'd3,  // product t*t
    OP_DIVSET = 4'd4,  // set divider for a/b
    OP_RSET   = 4'd5,  // set divider for x/t
    OP_CSET   = 4'd6,  // set divider for x/(t*t)
    OP_DSTEP  = 4'd7,  // one divider bit
    OP_DIVOUT = 4'd8,  // result from quotient
    OP_UPD    = 4'd9,  // newton update of t
    OP_ROOTOUT= 4'd10, // result from t
    OP_NONE   = 4'd11,
    OP_DIFF   = 4'd12  // register quotient minus t
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic       iter_lim;
  } dp_cmd_t;

  typedef struct packed {
    logic       div_done;
    logic       conv;
  } dp_stat_t;

endpackage

// ===== hw/rtl/fixed_point_16_16_math_unit.sv =====
// fixed_point_16_16_math_unit: top level, controller plus datapath
// depends on fpmu_pkg, fpmu_ctrl, fpmu_datapath
// multiply runs load, product and result steps; float, abs and spare resolve at load
// divide and each newton step of the roots (cube adds a square) run the 48-step divider
// one command at a time; busy high until the result strobe (done) ends
// rst synchronous, returns controller to idle; receiver cannot stall
module fixed_point_16_16_math_unit import fpmu_pkg::*; #(
  parameter int MAX_ITERATIONS = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         cmd,
  input  logic signed [31:0] operand_a,
  input  logic signed [31:0] operand_b,
  output logic               done,
  output logic signed [31:0] result,
  output logic [1:0]         status
);

  dp_cmd_t  dcmd;
  dp_stat_t dstat;

  fpmu_ctrl #(.MAX_ITERATIONS(MAX_ITERATIONS)) u_ctrl (
    .clk, .rst, .start, .cmd, .dstat, .dcmd, .busy, .done
  );

  fpmu_datapath u_dp (
    .clk, .cmd, .operand_a, .operand_b, .dcmd, .dstat, .result, .status
  );

endmodule

// ===== hw/rtl/fpmu_datapath.sv =====
// fpmu_datapath: operand registers, multiplier, radix-2 divider, newton update
// depends on fpmu_pkg
module fpmu_datapath import fpmu_pkg::*; (
  input  logic                clk,
  input  logic [2:0]          cmd,
  input  logic signed [31:0]  operand_a,
  input  logic signed [31:0]  operand_b,
  input  dp_cmd_t             dcmd,
  output dp_stat_t            dstat,
  output logic signed [31:0]  result,
  output logic [1:0]          status
);

  logic signed [31:0] a, b, t;
  logic signed [63:0] prod;
  logic [47:0] dnum;       // magnitude of dividend (a<<16)
  logic [48:0] drem;
  logic [47:0] dquo;
  logic [31:0] dden;
  logic [5:0]  dcnt;
  logic        dneg, dzero, dsnega;
  logic        conv;
  logic        cube;
  logic [31:0] dmag;
  logic        dsgn;

  // float conversion
  logic [7:0]  fe;
  logic [23:0] fsig;
  logic signed [9:0] fsh;
  logic [32:0] fmag;
  logic signed [31:0] fres;
  logic [1:0]  fst;

  always_comb begin
    fe = operand_a[30:23];
    fsig = {1'b1, operand_a[22:0]};
    fsh = $signed({2'b00, fe}) - 10'sd134;
    fmag = '0;
    fres = '0;
    fst = ST_OK;
    if (fsh >= 0) fmag = {9'd0, fsig} << fsh[3:0];
    else if (fsh > -24) fmag = {9'd0, fsig} >> (-fsh);
    if (fe == 8'd0) begin
      fres = '0;
    end else if (fe == 8'hff || fsh > 8) begin
      fst = ST_OVERFLOW;
      fres = operand_a[31] ? FIX_MIN : FIX_MAX;
    end else if (operand_a[31]) begin
      if (fmag > 33'h080000000) begin
        fst = ST_OVERFLOW;
        fres = FIX_MIN;
      end else begin
        fres = 32'(-$signed(fmag));
      end
    end else if (fmag > 33'h07fffffff) begin
      fst = ST_OVERFLOW;
      fres = FIX_MAX;
    end else begin
      fres = fmag[31:0];
    end
  end

  // divider signals
  logic [48:0] dtrial;
  logic signed [48:0] qsigned;
  logic signed [31:0] qsat;
  logic [1:0]  qst;
  logic signed [31:0] ddsrc;
  logic signed [33:0] dt, diff;
  logic [63:0] dprod;
  logic [31:0] dq;

  always_comb begin
    dtrial = {drem[47:0], dnum[47]} - {17'd0, dden};
    qsigned = dneg ? -$signed({1'b0, dquo}) : $signed({1'b0, dquo});
    qst = ST_OK;
    qsat = qsigned[31:0];
    if (dzero) begin
      qst = ST_DIVZERO;
      qsat = dsnega ? FIX_MIN : FIX_MAX;
    end else if (qsigned > 49'sd2147483647) begin
      qst = ST_OVERFLOW;
      qsat = FIX_MAX;
    end else if (qsigned < -49'sd2147483648) begin
      qst = ST_OVERFLOW;
      qsat = FIX_MIN;
    end
    case (dcmd.op)
      OP_DIVSET: ddsrc = b;
      OP_RSET:   ddsrc = t;
      default:   ddsrc = prod[47:16];
    endcase
    diff = 34'(qsat) - 34'(t);
    // step magnitude halved or thirded, truncated toward zero
    dprod = 64'(dmag) * 64'(RECIP3);
    dq = cube ? {1'b0, dprod[63:33]} : {1'b0, dmag[31:1]};
    dt = dsgn ? -$signed({2'b00, dq}) : $signed({2'b00, dq});
  end

  assign dstat.div_done = (dcnt == 6'd0);
  assign dstat.conv = conv;

  always_ff @(posedge clk) begin
    case (dcmd.op)
      OP_LOAD: begin
        a <= operand_a;
        b <= operand_b;
        t <= FIX_TWO;
        cube <= (cmd == CMD_CBRT);
        conv <= 1'b0;
        status <= ST_OK;
        result <= '0;
        case (cmd)
          CMD_FLT: begin
            result <= fres;
            status <= fst;
          end
          CMD_ABS: begin
            if (operand_a == FIX_MIN) begin
              result <= FIX_MAX;
              status <= ST_OVERFLOW;
            end else begin
              result <= operand_a[31] ? -operand_a : operand_a;
            end
          end
          default: ;
        endcase
      end
      OP_MUL:    prod <= 64'(a) * 64'(b);
      OP_SQ:     prod <= 64'(t) * 64'(t);
      OP_MULOUT: begin
        result <= prod[47:16];
        status <= ST_OK;
      end
      OP_DIVSET, OP_RSET, OP_CSET: begin
        dnum <= {a[31] ? 32'(-a) : 32'(a), 16'd0};
        dden <= ddsrc[31] ? 32'(-ddsrc) : 32'(ddsrc);
        dneg <= a[31] ^ ddsrc[31];
        dsnega <= a[31];
        dzero <= (ddsrc == 32'sd0);
        drem <= '0;
        dquo <= '0;
        dcnt <= 6'd48;
      end
      OP_DSTEP: begin
        dnum <= {dnum[46:0], 1'b0};
        dcnt <= dcnt - 6'd1;
        if (!dtrial[48]) begin
          drem <= dtrial;
          dquo <= {dquo[46:0], 1'b1};
        end else begin
          drem <= {drem[47:0], dnum[47]};
          dquo <= {dquo[46:0], 1'b0};
        end
      end
      OP_DIVOUT: begin
        result <= qsat;
        status <= qst;
      end
      OP_DIFF: begin
        dmag <= diff[33] ? 32'(-diff) : diff[31:0];
        dsgn <= diff[33];
      end
      OP_UPD: begin
        t <= t + dt[31:0];
        conv <= (dt <= STEP_TOL) && (dt >= -STEP_TOL);
      end
      OP_ROOTOUT: begin
        result <= t;
        status <= dcmd.iter_lim ? ST_ITERLIM : ST_OK;
      end
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/fpmu_ctrl.sv =====
// fpmu_ctrl: command sequencer for the 16.16 math unit
// depends on fpmu_pkg
module fpmu_ctrl import fpmu_pkg::*; #(
  parameter int MAX_ITERATIONS = 64
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      start,
  input  logic [2:0] cmd,
  input  dp_stat_t  dstat,
  output dp_cmd_t   dcmd,
  output logic      busy,
  output logic      done
);

  localparam int IW = $clog2(MAX_ITERATIONS + 1);

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DISP = 8'b00000010,
    S_MUL  = 8'b00000100,
    S_DSET = 8'b00001000,
    S_DIV  = 8'b00010000,
    S_UPD  = 8'b00100000,
    S_OUT  = 8'b01000000,
    S_CHK  = 8'b10000000
  } state_t;

  state_t state, state_next;
  logic [2:0] c;
  logic [IW-1:0] iter;
  logic lim;

  always_comb begin
    state_next = state;
    dcmd.op = OP_NONE;
    dcmd.iter_lim = lim;
    case (state)
      S_IDLE: if (start) begin
        dcmd.op = OP_LOAD;
        state_next = S_DISP;
      end
      S_DISP: begin
        case (c)
          CMD_MUL: begin
            dcmd.op = OP_MUL;
            state_next = S_MUL;
          end
          CMD_DIV: begin
            dcmd.op = OP_DIVSET;
            state_next = S_DIV;
          end
          CMD_SQRT: begin
            dcmd.op = OP_RSET;
            state_next = S_DIV;
          end
          CMD_CBRT: begin
            dcmd.op = OP_SQ;
            state_next = S_DSET;
          end
          default: state_next = S_OUT;
        endcase
      end
      S_MUL: begin
        dcmd.op = OP_MULOUT;
        state_next = S_OUT;
      end
      S_DSET: begin
        dcmd.op = OP_CSET;
        state_next = S_DIV;
      end
      S_DIV: begin
        if (!dstat.div_done) dcmd.op = OP_DSTEP;
        else if (c == CMD_DIV) begin
          dcmd.op = OP_DIVOUT;
          state_next = S_OUT;
        end else begin
          dcmd.op = OP_DIFF;
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        dcmd.op = OP_UPD;
        state_next = S_CHK;
      end
      S_CHK: begin
        if (dstat.conv || lim) begin
          dcmd.op = OP_ROOTOUT;
          state_next = S_OUT;
        end else if (c == CMD_CBRT) begin
          dcmd.op = OP_SQ;
          state_next = S_DSET;
        end else begin
          dcmd.op = OP_RSET;
          state_next = S_DIV;
        end
      end
      S_OUT: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  assign lim = (iter == IW'(MAX_ITERATIONS)) && !dstat.conv;
  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
    if (state == S_IDLE && start) begin
      c <= cmd;
      iter <= '0;
    end else if (dcmd.op == OP_UPD) begin
      iter <= iter + IW'(1);
    end
  end

endmodule

// ===== hw/rtl/fpmu_checker.sv =====
// fpmu_checker: port-level assertions for the math unit
// depends on fpmu_pkg; bound to fixed_point_16_16_math_unit
module fpmu_checker import fpmu_pkg::*; (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic done,
  input logic signed [31:0] result,
  input logic [1:0] status
);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy) else $error("accepted word did not raise busy");

  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy) else $error("strobe while idle");

  a_done_pulse: assert property (@(posedge clk) disable iff (rst)
    done |=> !done) else $error("strobe longer than one cycle");

  a_done_free: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy) else $error("busy after strobe");

  a_done_known: assert property (@(posedge clk) disable iff (rst)
    done |-> !$isunknown({result, status})) else $error("unknown result word");

endmodule

bind fixed_point_16_16_math_unit fpmu_checker u_chk (
  .clk, .rst, .start, .busy, .done, .result, .status
);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// tb_top: self-checking bench for the 16.16 fixed-point math unit
// depends on fpmu_pkg and fixed_point_16_16_math_unit; drives random and directed words,
// predicts each result in-bench and checks it against the result strobe
module tb_top;
  import fpmu_pkg::*;

  localparam int ITER_CAP = 64;
  localparam int STALL_LIMIT = 20000;
  localparam logic [2:0] CMD_SPARE_LO = 3'd6;
  localparam logic [2:0] CMD_SPARE_HI = 3'd7;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    bit                 drain_first;
  } cmd_word_t;

  typedef struct {
    logic signed [31:0] value;
    logic [1:0]         st;
  } answer_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         cmd = '0;
  logic signed [31:0] operand_a = '0;
  logic signed [31:0] operand_b = '0;
  logic               done;
  logic signed [31:0] result;
  logic [1:0]         status;

  cmd_word_t pending_words[$];
  answer_t   due_answers[$];
  int        gap_left = 0;
  int        stall_cycles = 0;
  int        mismatches = 0;
  bit        fail_seen = 1'b0;
  bit        steady_run = 1'b0;

  fixed_point_16_16_math_unit #(.MAX_ITERATIONS(ITER_CAP)) u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .operand_a(operand_a), .operand_b(operand_b),
    .done(done), .result(result), .status(status)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint mul_wrap(longint x, longint y);
    logic [63:0] prod;
    prod = x * y;
    return longint'(signed'(prod[47:16]));
  endfunction

  function automatic longint div_sat(longint x, longint y, output logic [1:0] st);
    longint q;
    st = ST_OK;
    if (y == 0) begin
      st = ST_DIVZERO;
      return (x < 0) ? longint'(FIX_MIN) : longint'(FIX_MAX);
    end
    q = (x * 65536) / y;
    if (q > longint'(FIX_MAX)) begin
      st = ST_OVERFLOW;
      return longint'(FIX_MAX);
    end
    if (q < longint'(FIX_MIN)) begin
      st = ST_OVERFLOW;
      return longint'(FIX_MIN);
    end
    return q;
  endfunction

  function automatic longint float_to_fix(logic [31:0] bits, output logic [1:0] st);
    logic [7:0]  ex;
    logic [63:0] sig;
    logic [63:0] mag;
    int          sh;
    ex = bits[30:23];
    sig = {40'd0, 1'b1, bits[22:0]};
    sh = int'(ex) - 134;
    st = ST_OK;
    if (ex == 8'd0) return 0;
    if (ex == 8'hff || sh > 8) begin
      st = ST_OVERFLOW;
      return bits[31] ? longint'(FIX_MIN) : longint'(FIX_MAX);
    end
    if (sh >= 0) mag = sig << sh;
    else if (sh <= -24) mag = 0;
    else mag = sig >> (-sh);
    if (bits[31]) begin
      if (mag > 64'h8000_0000) begin
        st = ST_OVERFLOW;
        return longint'(FIX_MIN);
      end
      return -longint'(mag);
    end
    if (mag > 64'h7fff_ffff) begin
      st = ST_OVERFLOW;
      return longint'(FIX_MAX);
    end
    return longint'(mag);
  endfunction

  function automatic longint newton_root(longint x, bit cube, output logic [1:0] st);
    longint     t;
    longint     dt;
    logic [1:0] unused_st;
    logic [63:0] sum;
    t = longint'(FIX_TWO);
    for (int n = 0; n < ITER_CAP; n++) begin
      if (cube) dt = (div_sat(x, mul_wrap(t, t), unused_st) - t) / 3;
      else dt = (div_sat(x, t, unused_st) - t) / 2;
      sum = t + dt;
      t = longint'(signed'(sum[31:0]));
      if (dt <= 6 && dt >= -6) begin
        st = ST_OK;
        return t;
      end
    end
    st = ST_ITERLIM;
    return t;
  endfunction

  function automatic answer_t predict_answer(logic [2:0] op, logic signed [31:0] a,
                                             logic signed [31:0] b);
    answer_t ans;
    longint  r;
    logic [1:0] st;
    logic [63:0] rb;
    st = ST_OK;
    r = 0;
    case (op)
      CMD_MUL:  r = mul_wrap(a, b);
      CMD_DIV:  r = div_sat(a, b, st);
      CMD_FLT:  r = float_to_fix(a, st);
      CMD_ABS: begin
        if (a == FIX_MIN) begin
          r = longint'(FIX_MAX);
          st = ST_OVERFLOW;
        end else begin
          r = (a < 0) ? -longint'(a) : longint'(a);
        end
      end
      CMD_SQRT: r = newton_root(a, 1'b0, st);
      CMD_CBRT: r = newton_root(a, 1'b1, st);
      default: begin
        r = 0;
        st = ST_OK;
      end
    endcase
    rb = r;
    ans.value = rb[31:0];
    ans.st = st;
    return ans;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady_run) return 0;
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(10, 80);
  endfunction

  function automatic logic signed [31:0] rand_fix();
    int r;
    r = $urandom_range(9);
    if (r < 4) return $urandom;
    if (r < 8) return $signed($urandom_range(0, 32'h7ffff)) - 32'sh40000;
    case ($urandom_range(3))
      0: return FIX_MAX;
      1: return FIX_MIN;
      2: return 32'sh0;
      default: return -32'sh1;
    endcase
  endfunction

  function automatic logic [31:0] rand_float();
    logic [7:0] ex;
    if ($urandom_range(9) < 7) ex = $urandom_range(100, 145);
    else ex = $urandom_range(0, 255);
    return {1'($urandom), ex, 23'($urandom)};
  endfunction

  task automatic queue_word(logic [2:0] op, logic signed [31:0] a,
                            logic signed [31:0] b, bit drain);
    cmd_word_t w;
    w.op = op;
    w.a = a;
    w.b = b;
    w.drain_first = drain;
    pending_words.push_back(w);
  endtask

  task automatic queue_random(int idx);
    int         r;
    logic [2:0] op;
    logic signed [31:0] a;
    logic signed [31:0] b;
    r = $urandom_range(99);
    a = rand_fix();
    b = rand_fix();
    if (r < 18) op = CMD_MUL;
    else if (r < 36) op = CMD_DIV;
    else if (r < 52) begin
      op = CMD_FLT;
      a = rand_float();
    end else if (r < 62) op = CMD_ABS;
    else if (r < 99) begin
      op = (r < 81) ? CMD_SQRT : CMD_CBRT;
      if ($urandom_range(9) < 6) a = $urandom_range(0, 32'h7ffffff);
      else if (op == CMD_CBRT || $urandom_range(9) == 0) a = $urandom;
      else a = $urandom_range(0, 32'h7fffffff);
    end else op = ($urandom_range(1) != 0) ? CMD_SPARE_LO : CMD_SPARE_HI;
    queue_word(op, a, b, (idx % 100) == 50);
  endtask

  // driver
  always @(posedge clk) begin
    bit fire;
    int g;
    cmd_word_t w;
    if (rst) begin
      start <= 1'b0;
      gap_left <= 0;
    end else begin
      fire = start && !busy;
      g = gap_left;
      if (fire) begin
        due_answers.push_back(predict_answer(cmd, operand_a, operand_b));
        g = pick_gap();
      end
      if (start && !fire) begin
        // hold the word until accepted
      end else if (g > 0) begin
        start <= 1'b0;
        g--;
      end else if (pending_words.size() > 0 &&
                   (!pending_words[0].drain_first ||
                    (!fire && !start && !busy && !done))) begin
        w = pending_words.pop_front();
        start <= 1'b1;
        cmd <= w.op;
        operand_a <= w.a;
        operand_b <= w.b;
      end else begin
        start <= 1'b0;
      end
      gap_left <= g;
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    answer_t exp_ans;
    if (!rst) begin
      if (done) begin
        if (due_answers.size() == 0) begin
          fail_seen <= 1'b1;
          if (mismatches < 10)
            $display("unexpected result word %h status %0d", result, status);
          mismatches <= mismatches + 1;
        end else begin
          exp_ans = due_answers.pop_front();
          if (result !== exp_ans.value || status !== exp_ans.st) begin
            fail_seen <= 1'b1;
            if (mismatches < 10)
              $display("mismatch: expected %h/%0d got %h/%0d",
                       exp_ans.value, exp_ans.st, result, status);
            mismatches <= mismatches + 1;
          end
        end
      end
      if ((start && !busy) || done) stall_cycles <= 0;
      else if (stall_cycles >= STALL_LIMIT) begin
        $display("fixed_point_16_16_math_unit verification failed");
        $finish;
      end else stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    // directed words
    queue_word(CMD_MUL, FIX_MAX, FIX_MAX, 0);
    queue_word(CMD_MUL, FIX_MIN, FIX_MIN, 0);
    queue_word(CMD_MUL, 32'sh00018000, -32'sh00028000, 0);
    queue_word(CMD_DIV, 32'sh00010000, 32'sh0, 0);
    queue_word(CMD_DIV, -32'sh00010000, 32'sh0, 0);
    queue_word(CMD_DIV, FIX_MAX, 32'sh1, 0);
    queue_word(CMD_DIV, FIX_MIN, 32'sh1, 0);
    queue_word(CMD_DIV, -32'sh00070000, 32'sh00020000, 0);
    queue_word(CMD_FLT, 32'h00000000, 0, 0);
    queue_word(CMD_FLT, 32'h00400000, 0, 0);
    queue_word(CMD_FLT, 32'h7f800000, 0, 0);
    queue_word(CMD_FLT, 32'hff800000, 0, 0);
    queue_word(CMD_FLT, 32'h7fc00000, 0, 0);
    queue_word(CMD_FLT, 32'h47000000, 0, 0);
    queue_word(CMD_FLT, 32'hc7000000, 0, 0);
    queue_word(CMD_FLT, 32'hbfc00001, 0, 0);
    queue_word(CMD_FLT, 32'h33800000, 0, 0);
    queue_word(CMD_ABS, FIX_MIN, 0, 0);
    queue_word(CMD_ABS, -32'sh00012345, 0, 0);
    queue_word(CMD_SQRT, 32'sh0, 0, 0);
    queue_word(CMD_SQRT, 32'sh00040000, 0, 0);
    queue_word(CMD_SQRT, -32'sh00010000, 0, 1);
    queue_word(CMD_CBRT, 32'sh00080000, 0, 0);
    queue_word(CMD_CBRT, -32'sh001b0000, 0, 0);
    queue_word(CMD_SPARE_LO, FIX_MAX, FIX_MIN, 0);
    queue_word(CMD_SPARE_HI, -32'sh1, 32'sh1, 0);
    for (int i = 0; i < 880; i++) queue_random(i);

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    while (pending_words.size() > 300) @(negedge clk);
    steady_run = 1'b1;
    while (pending_words.size() > 200) @(negedge clk);
    steady_run = 1'b0;
    while (pending_words.size() > 0 || start || busy || done) @(negedge clk);
    repeat (60) @(negedge clk);
    if (due_answers.size() > 0 && mismatches < 10)
      $display("%0d results never arrived", due_answers.size());
    if (!fail_seen && due_answers.size() == 0)
      $display("fixed_point_16_16_math_unit verification clean");
    else $display("fixed_point_16_16_math_unit verification failed");
    $finish;
  end

endmodule
